FILE: hdl/assert_macros.svh
// Assertion helpers; expect clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: hdl/tga_rle_pkg.sv
package tga_rle_pkg;

  // result status codes
  localparam logic [2:0] ST_HDR_OK   = 3'd0;
  localparam logic [2:0] ST_BAD_SIZE = 3'd1;
  localparam logic [2:0] ST_BAD_TYPE = 3'd2;
  localparam logic [2:0] ST_PIXEL    = 3'd3;
  localparam logic [2:0] ST_CLIPPED  = 3'd4;

  // image type codes
  localparam logic [7:0] TYPE_RAW_COLOR = 8'd2;
  localparam logic [7:0] TYPE_RAW_GRAY  = 8'd3;
  localparam logic [7:0] TYPE_RLE_COLOR = 8'd10;
  localparam logic [7:0] TYPE_RLE_GRAY  = 8'd11;

  // header byte offsets
  localparam logic [4:0] HI_ID_LEN = 5'd0;
  localparam logic [4:0] HI_TYPE   = 5'd2;
  localparam logic [4:0] HI_W_LO   = 5'd12;
  localparam logic [4:0] HI_W_HI   = 5'd13;
  localparam logic [4:0] HI_H_LO   = 5'd14;
  localparam logic [4:0] HI_H_HI   = 5'd15;
  localparam logic [4:0] HI_DEPTH  = 5'd16;
  localparam logic [4:0] HI_LAST   = 5'd17;

  localparam logic [7:0] RUN_BIT_LIMIT = 8'd128;
  localparam logic [7:0] RUN_BIAS      = 8'd127;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] pixel_value;
    logic [7:0]  repeat_count;
    logic [15:0] image_width;
    logic [15:0] image_height;
    logic [2:0]  pixel_bytes;
    logic        last;
  } res_t;

endpackage

FILE: hdl/tga_rle_stream_decoder_core.sv
// Channel | Handshake          | Payload
// in      | in_valid/in_ready  | in_data_byte, in_start_of_file
// out     | out_valid/out_ready| status, pixel_value, repeat_count, image_width,
//         |                    | image_height, pixel_bytes, last
//
// One byte is taken per cycle while in_ready is high; the parser updates all state in that cycle.
// A result passes through the queue and then the output register before it reaches out_valid.
// Reset leaves the parser idle until a start_of_file byte.
// in_ready drops only while the QUEUE_DEPTH-entry queue is full.
// Results queue up behind a stalled output and hold back input once the queue fills.
module tga_rle_stream_decoder_core #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_start_of_file,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_status,
  output logic [31:0] out_pixel_value,
  output logic [7:0]  out_repeat_count,
  output logic [15:0] out_image_width,
  output logic [15:0] out_image_height,
  output logic [2:0]  out_pixel_bytes,
  output logic        out_last
);
  import tga_rle_pkg::*;

  logic fire;
  logic res_vld;
  res_t res;
  logic q_full;
  logic q_nonempty;
  logic q_pop;
  res_t q_head;

  assign in_ready = !q_full;
  assign fire     = in_valid && in_ready;

  tga_rle_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .fire          (fire),
    .data_byte     (in_data_byte),
    .start_of_file (in_start_of_file),
    .res_vld       (res_vld),
    .res           (res)
  );

  tga_rle_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_vld),
    .push_data (res),
    .pop       (q_pop),
    .full      (q_full),
    .nonempty  (q_nonempty),
    .head      (q_head)
  );

  tga_rle_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_nonempty       (q_nonempty),
    .q_head           (q_head),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_pixel_value  (out_pixel_value),
    .out_repeat_count (out_repeat_count),
    .out_image_width  (out_image_width),
    .out_image_height (out_image_height),
    .out_pixel_bytes  (out_pixel_bytes),
    .out_last         (out_last)
  );

endmodule

FILE: hdl/tga_rle_front.sv
module tga_rle_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                fire,
  input  logic [7:0]          data_byte,
  input  logic                start_of_file,
  output logic                res_vld,
  output tga_rle_pkg::res_t   res
);
  import tga_rle_pkg::*;

  typedef enum logic [5:0] {
    PH_IDLE   = 6'b000001,
    PH_HEADER = 6'b000010,
    PH_IDSKIP = 6'b000100,
    PH_PIXEL  = 6'b001000,
    PH_PKTHDR = 6'b010000,
    PH_DONE   = 6'b100000
  } phase_t;

  phase_t      phase_r, phase_nxt, ph;
  logic [4:0]  hidx_r, hidx_nxt, hidx;
  logic [7:0]  id_r, id_nxt;
  logic [15:0] width_r, width_nxt;
  logic [15:0] height_r, height_nxt;
  logic [2:0]  depth_r, depth_nxt;
  logic [7:0]  type_r, type_nxt;
  logic [31:0] pl_r, pl_nxt;
  logic [7:0]  pkt_r, pkt_nxt;
  logic        run_r, run_nxt;
  logic [1:0]  bip_r, bip_nxt;
  logic [31:0] asm_r, asm_nxt;

  logic        coded;
  logic        size_ok;
  logic        type_ok;
  phase_t      data_ph;
  logic [31:0] asm_upd;
  logic [31:0] word;
  logic        clip;
  logic [7:0]  rep;
  logic [31:0] pl_left;

  assign coded   = type_r inside {TYPE_RLE_COLOR, TYPE_RLE_GRAY};
  assign data_ph = coded ? PH_PKTHDR : PH_PIXEL;
  assign size_ok = (width_r != 16'd0) && (height_r != 16'd0) &&
                   (depth_r inside {3'd1, 3'd3, 3'd4});
  assign type_ok = (type_r inside {TYPE_RAW_COLOR, TYPE_RAW_GRAY}) || coded;

  always_comb begin
    asm_upd = asm_r;
    asm_upd[{bip_r, 3'b000} +: 8] = data_byte;
    case (depth_r)
      3'd1:    word = {4{asm_upd[7:0]}};
      3'd3:    word = {8'hFF, asm_upd[23:0]};
      default: word = asm_upd;
    endcase
    clip    = coded && run_r && ({24'd0, pkt_r} > pl_r);
    if (coded && run_r) begin
      rep = clip ? pl_r[7:0] : pkt_r;
    end else begin
      rep = 8'd1;
    end
    pl_left = pl_r - {24'd0, rep};
  end

  always_comb begin
    ph         = start_of_file ? PH_HEADER : phase_r;
    hidx       = start_of_file ? 5'd0 : hidx_r;
    phase_nxt  = phase_r;
    hidx_nxt   = hidx_r;
    id_nxt     = id_r;
    width_nxt  = width_r;
    height_nxt = height_r;
    depth_nxt  = depth_r;
    type_nxt   = type_r;
    pl_nxt     = pl_r;
    pkt_nxt    = pkt_r;
    run_nxt    = run_r;
    bip_nxt    = bip_r;
    asm_nxt    = asm_r;
    res_vld    = 1'b0;
    res.status       = ST_HDR_OK;
    res.pixel_value  = 32'd0;
    res.repeat_count = 8'd0;
    res.image_width  = width_r;
    res.image_height = height_r;
    res.pixel_bytes  = depth_r;
    res.last         = 1'b0;

    if (fire) begin
      phase_nxt = ph;
      hidx_nxt  = hidx;
      case (ph)
        PH_HEADER: begin
          case (hidx)
            HI_ID_LEN: id_nxt = data_byte;
            HI_TYPE:   type_nxt = data_byte;
            HI_W_LO:   width_nxt[7:0] = data_byte;
            HI_W_HI:   width_nxt[15:8] = data_byte;
            HI_H_LO:   height_nxt[7:0] = data_byte;
            HI_H_HI:   height_nxt[15:8] = data_byte;
            HI_DEPTH:  depth_nxt = (data_byte[7:3] <= 5'd4) ? data_byte[5:3] : 3'd0;
            default: ;
          endcase
          if (hidx == HI_LAST) begin
            hidx_nxt = 5'd0;
            res_vld  = 1'b1;
            if (!size_ok) begin
              res.status = ST_BAD_SIZE;
              res.last   = 1'b1;
              phase_nxt  = PH_DONE;
            end else if (!type_ok) begin
              res.status = ST_BAD_TYPE;
              res.last   = 1'b1;
              phase_nxt  = PH_DONE;
            end else begin
              pl_nxt    = width_r * height_r;
              asm_nxt   = '1;
              bip_nxt   = 2'd0;
              pkt_nxt   = 8'd0;
              run_nxt   = 1'b0;
              phase_nxt = (id_r != 8'd0) ? PH_IDSKIP : data_ph;
            end
          end else begin
            hidx_nxt = hidx + 5'd1;
          end
        end
        PH_IDSKIP: begin
          id_nxt = id_r - 8'd1;
          if (id_r == 8'd1) begin
            phase_nxt = data_ph;
          end
        end
        PH_PKTHDR: begin
          if (data_byte < RUN_BIT_LIMIT) begin
            pkt_nxt = data_byte + 8'd1;
            run_nxt = 1'b0;
          end else begin
            pkt_nxt = data_byte - RUN_BIAS;
            run_nxt = 1'b1;
          end
          bip_nxt   = 2'd0;
          phase_nxt = PH_PIXEL;
        end
        PH_PIXEL: begin
          asm_nxt = asm_upd;
          if (({1'b0, bip_r} + 3'd1) < depth_r) begin
            bip_nxt = bip_r + 2'd1;
          end else begin
            bip_nxt = 2'd0;
            if (coded && run_r) begin
              pkt_nxt = 8'd0;
            end else if (coded && (pkt_r != 8'd0)) begin
              pkt_nxt = pkt_r - 8'd1;
            end
            pl_nxt           = pl_left;
            res_vld          = 1'b1;
            res.status       = clip ? ST_CLIPPED : ST_PIXEL;
            res.pixel_value  = word;
            res.repeat_count = rep;
            res.last         = (pl_left == 32'd0);
            if (pl_left == 32'd0) begin
              phase_nxt = PH_DONE;
            end else if (coded && (pkt_nxt == 8'd0)) begin
              phase_nxt = PH_PKTHDR;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_IDLE;
      hidx_r   <= 5'd0;
      id_r     <= 8'd0;
      width_r  <= 16'd0;
      height_r <= 16'd0;
      depth_r  <= 3'd0;
      type_r   <= 8'd0;
      pl_r     <= 32'd0;
      pkt_r    <= 8'd0;
      run_r    <= 1'b0;
      bip_r    <= 2'd0;
      asm_r    <= '1;
    end else begin
      phase_r  <= phase_nxt;
      hidx_r   <= hidx_nxt;
      id_r     <= id_nxt;
      width_r  <= width_nxt;
      height_r <= height_nxt;
      depth_r  <= depth_nxt;
      type_r   <= type_nxt;
      pl_r     <= pl_nxt;
      pkt_r    <= pkt_nxt;
      run_r    <= run_nxt;
      bip_r    <= bip_nxt;
      asm_r    <= asm_nxt;
    end
  end

endmodule

FILE: hdl/tga_rle_queue.sv
module tga_rle_queue #(
  parameter int DEPTH = 2
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  tga_rle_pkg::res_t   push_data,
  input  logic                pop,
  output logic                full,
  output logic                nonempty,
  output tga_rle_pkg::res_t   head
);
  import tga_rle_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  res_t          mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_push;
  logic          do_pop;

  assign full     = (count_r == CW'(DEPTH));
  assign nonempty = (count_r != '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && nonempty;
  assign head     = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

FILE: hdl/tga_rle_back.sv
module tga_rle_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_nonempty,
  input  tga_rle_pkg::res_t   q_head,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [2:0]          out_status,
  output logic [31:0]         out_pixel_value,
  output logic [7:0]          out_repeat_count,
  output logic [15:0]         out_image_width,
  output logic [15:0]         out_image_height,
  output logic [2:0]          out_pixel_bytes,
  output logic                out_last
);
  import tga_rle_pkg::*;

  logic valid_r, valid_nxt;
  res_t data_r, data_nxt;
  logic is_pix;

  assign q_pop  = q_nonempty && (!valid_r || out_ready);
  assign is_pix = q_head.status inside {ST_PIXEL, ST_CLIPPED};

  always_comb begin
    valid_nxt = valid_r;
    data_nxt  = data_r;
    if (q_pop) begin
      valid_nxt = 1'b1;
      data_nxt  = q_head;
      // header fields only travel with header and error transfers
      if (is_pix) begin
        data_nxt.image_width  = 16'd0;
        data_nxt.image_height = 16'd0;
        data_nxt.pixel_bytes  = 3'd0;
      end
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign out_valid        = valid_r;
  assign out_status       = data_r.status;
  assign out_pixel_value  = data_r.pixel_value;
  assign out_repeat_count = data_r.repeat_count;
  assign out_image_width  = data_r.image_width;
  assign out_image_height = data_r.image_height;
  assign out_pixel_bytes  = data_r.pixel_bytes;
  assign out_last         = data_r.last;

endmodule

FILE: hdl/tga_rle_chk.sv
`include "assert_macros.svh"

module tga_rle_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  out_status,
  input logic [31:0] out_pixel_value,
  input logic [7:0]  out_repeat_count,
  input logic [15:0] out_image_width,
  input logic [15:0] out_image_height,
  input logic [2:0]  out_pixel_bytes,
  input logic        out_last
);
  import tga_rle_pkg::*;

  // hold a stalled result
  `ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_pixel_value) && $stable(out_status) && $stable(out_repeat_count) && $stable(out_last))

  // pixel transfers carry a count in range and no header fields
  `ASSERT_IMPLIES(a_pix_fields, out_valid && (out_status == ST_PIXEL || out_status == ST_CLIPPED), out_repeat_count != 8'd0 && out_repeat_count <= 8'd128 && out_image_width == 16'd0 && out_image_height == 16'd0 && out_pixel_bytes == 3'd0)

  // header transfers carry no pixel
  `ASSERT_IMPLIES(a_hdr_fields, out_valid && (out_status == ST_HDR_OK || out_status == ST_BAD_SIZE || out_status == ST_BAD_TYPE), out_repeat_count == 8'd0 && out_pixel_value == 32'd0 && out_pixel_bytes <= 3'd4)

  // errors and clipped runs end the image
  `ASSERT_IMPLIES(a_end_flag, out_valid && (out_status == ST_BAD_SIZE || out_status == ST_BAD_TYPE || out_status == ST_CLIPPED), out_last)

endmodule

bind tga_rle_stream_decoder_core tga_rle_chk u_chk (.*);
